[rtl/core/diffie_hellman_shared_key_assert.svh]
// Assertion macros used by the checker file of the shared-key block.
`ifndef DIFFIE_HELLMAN_SHARED_KEY_ASSERT_SVH
`define DIFFIE_HELLMAN_SHARED_KEY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DHSK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dhsk assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DHSK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dhsk assertion failed");

`endif

[rtl/core/dhsk_pkg.sv]
// Types, constants and microcode table of the shared-key block.
package dhsk_pkg;

	localparam int MOD_BITS = 32;
	localparam int CNT_W    = $clog2(MOD_BITS);
	localparam int EXP_BITS = 32;
	localparam int EBIT_W   = $clog2(EXP_BITS);
	localparam int CFG_W    = 32;
	localparam int STEP_W   = 4;

	localparam logic [1:0]  REG_PRIME = 2'd0;
	localparam logic [1:0]  REG_GEN   = 2'd1;
	localparam logic [31:0] PRIME_RST = 32'd23;
	localparam logic [31:0] GEN_RST   = 32'd9;

	typedef struct packed {
		logic [31:0] first_secret;
		logic [31:0] second_secret;
	} in_t;

	typedef struct packed {
		logic [31:0] first_public;
		logic [31:0] second_public;
		logic [31:0] shared_key;
		logic        keys_agree;
	} out_t;

	typedef struct packed {
		logic                start;
		logic [MOD_BITS-1:0] x;
		logic [MOD_BITS-1:0] y;
	} mul_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [MOD_BITS-1:0] prod;
	} mul_rsp_t;

	typedef enum logic [3:0] {
		U_ACCEPT, U_CHKP, U_MUL, U_SETG, U_INIT, U_TBIT, U_LOOP, U_SAVE, U_EMIT, U_EMITZ
	} uop_t;

	typedef enum logic {X_ONE, X_R} xsel_t;
	typedef enum logic [1:0] {Y_GEN, Y_R, Y_BASE} ysel_t;

	// pass order: g^a, g^b, (g^b)^a, (g^a)^b
	typedef enum logic [1:0] {PASS_PUB_A, PASS_PUB_B, PASS_KEY_A, PASS_KEY_B} pass_t;

	typedef struct packed {
		uop_t              op;
		xsel_t             xsel;
		ysel_t             ysel;
		logic [STEP_W-1:0] nxt;
		logic [STEP_W-1:0] jmp;
	} ucw_t;

	// step addresses
	localparam logic [STEP_W-1:0] S_ACCEPT = 4'd0;
	localparam logic [STEP_W-1:0] S_CHKP   = 4'd1;
	localparam logic [STEP_W-1:0] S_REDG   = 4'd2;
	localparam logic [STEP_W-1:0] S_SETG   = 4'd3;
	localparam logic [STEP_W-1:0] S_INIT   = 4'd4;
	localparam logic [STEP_W-1:0] S_SQR    = 4'd5;
	localparam logic [STEP_W-1:0] S_TBIT   = 4'd6;
	localparam logic [STEP_W-1:0] S_MULB   = 4'd7;
	localparam logic [STEP_W-1:0] S_LOOP   = 4'd8;
	localparam logic [STEP_W-1:0] S_SAVE   = 4'd9;
	localparam logic [STEP_W-1:0] S_EMIT   = 4'd10;
	localparam logic [STEP_W-1:0] S_EMITZ  = 4'd11;

	function automatic ucw_t ucode(input logic [STEP_W-1:0] s);
		ucw_t w;
		w = '{op: U_ACCEPT, xsel: X_R, ysel: Y_R, nxt: S_CHKP, jmp: S_ACCEPT};
		case (s)
			S_ACCEPT: w = '{op: U_ACCEPT, xsel: X_R,   ysel: Y_R,    nxt: S_CHKP,   jmp: S_ACCEPT};
			S_CHKP:   w = '{op: U_CHKP,   xsel: X_R,   ysel: Y_R,    nxt: S_REDG,   jmp: S_EMITZ};
			S_REDG:   w = '{op: U_MUL,    xsel: X_ONE, ysel: Y_GEN,  nxt: S_SETG,   jmp: S_SETG};
			S_SETG:   w = '{op: U_SETG,   xsel: X_R,   ysel: Y_R,    nxt: S_INIT,   jmp: S_INIT};
			S_INIT:   w = '{op: U_INIT,   xsel: X_R,   ysel: Y_R,    nxt: S_SQR,    jmp: S_SQR};
			S_SQR:    w = '{op: U_MUL,    xsel: X_R,   ysel: Y_R,    nxt: S_TBIT,   jmp: S_TBIT};
			S_TBIT:   w = '{op: U_TBIT,   xsel: X_R,   ysel: Y_R,    nxt: S_MULB,   jmp: S_LOOP};
			S_MULB:   w = '{op: U_MUL,    xsel: X_R,   ysel: Y_BASE, nxt: S_LOOP,   jmp: S_LOOP};
			S_LOOP:   w = '{op: U_LOOP,   xsel: X_R,   ysel: Y_R,    nxt: S_SAVE,   jmp: S_SQR};
			S_SAVE:   w = '{op: U_SAVE,   xsel: X_R,   ysel: Y_R,    nxt: S_EMIT,   jmp: S_INIT};
			S_EMIT:   w = '{op: U_EMIT,   xsel: X_R,   ysel: Y_R,    nxt: S_ACCEPT, jmp: S_ACCEPT};
			S_EMITZ:  w = '{op: U_EMITZ,  xsel: X_R,   ysel: Y_R,    nxt: S_ACCEPT, jmp: S_ACCEPT};
			default:  w = '{op: U_ACCEPT, xsel: X_R,   ysel: Y_R,    nxt: S_ACCEPT, jmp: S_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

[rtl/core/diffie_hellman_shared_key.sv]
// Top level: microcoded Diffie-Hellman public values and shared key over a modular multiplier.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  in       | in        | in_valid / in_stall   | in_data: first_secret, second_secret
//  out      | out       | out_valid / out_stall | out_data: publics, shared_key, keys_agree
//  cfg      | in        | cfg_we               | cfg_index, cfg_data (prime, generator)
//
// One item at a time. A product runs a start, one double-and-add step per bit of y and
// a done; an exponentiation squares for every exponent bit, multiplies by the base for
// each one bit and passes the bit test and loop steps per bit. An item first reduces g
// mod p; a modulus below two skips the math and the item emits zero values.
// Reset (arst_n low) loads p=23, g=9 and returns the sequencer to the accept step.
// A stalled result waits in the output register while the next item is transferred and
// worked on; the sequencer holds at the emit step only while that register is full.
module diffie_hellman_shared_key import dhsk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// configuration
	logic [31:0] prime_q;
	logic [31:0] gen_q;

	// sequencer
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	ucw_t              uc;
	logic              mwait_q;
	logic [EBIT_W-1:0] ebit_q;
	pass_t             pass_q;

	// datapath
	logic [31:0]         a_q;
	logic [31:0]         b_q;
	logic [MOD_BITS-1:0] gr_q;   // g mod p
	logic [MOD_BITS-1:0] pa_q;   // g^a
	logic [MOD_BITS-1:0] pb_q;   // g^b
	logic [MOD_BITS-1:0] ka_q;   // (g^b)^a
	logic [MOD_BITS-1:0] kb_q;   // (g^a)^b
	logic [MOD_BITS-1:0] r_q;    // running power

	logic [MOD_BITS-1:0] p_w;
	logic [MOD_BITS-1:0] gen_w;
	logic                p_small;
	logic [MOD_BITS-1:0] base;
	logic [31:0]         expo;
	logic                exp_bit;

	// control strobes
	logic in_take;
	logic out_free;
	logic out_load;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	out_t out_q;
	logic out_valid_q;

	assign uc      = ucode(step_q);
	assign p_w     = MOD_BITS'(prime_q);
	assign gen_w   = MOD_BITS'(gen_q);
	assign p_small = p_w < MOD_BITS'(2);

	// per pass: which base and which exponent
	always_comb begin
		case (pass_q)
			PASS_PUB_A: begin base = gr_q; expo = a_q; end
			PASS_PUB_B: begin base = gr_q; expo = b_q; end
			PASS_KEY_A: begin base = pb_q; expo = a_q; end
			PASS_KEY_B: begin base = pa_q; expo = b_q; end
			default:    begin base = gr_q; expo = a_q; end
		endcase
	end

	assign exp_bit  = expo[ebit_q];
	assign out_free = !out_valid_q || !out_stall;

	// next step
	always_comb begin
		step_nxt = step_q;
		case (uc.op)
			U_ACCEPT: if (in_valid) step_nxt = uc.nxt;
			U_CHKP:   step_nxt = p_small ? uc.jmp : uc.nxt;
			U_MUL:    if (mul_rsp.done) step_nxt = uc.nxt;
			U_SETG:   step_nxt = uc.nxt;
			U_INIT:   step_nxt = uc.nxt;
			U_TBIT:   step_nxt = exp_bit ? uc.nxt : uc.jmp;
			U_LOOP:   step_nxt = (ebit_q != '0) ? uc.jmp : uc.nxt;
			U_SAVE:   step_nxt = (pass_q == PASS_KEY_B) ? uc.nxt : uc.jmp;
			U_EMIT:   if (out_free) step_nxt = uc.nxt;
			U_EMITZ:  if (out_free) step_nxt = uc.nxt;
			default:  step_nxt = S_ACCEPT;
		endcase
	end

	// strobes and multiplier operands from the control word
	always_comb begin
		in_take       = (uc.op == U_ACCEPT) && in_valid;
		out_load      = ((uc.op == U_EMIT) || (uc.op == U_EMITZ)) && out_free;
		mul_req.start = (uc.op == U_MUL) && !mwait_q;
		case (uc.xsel)
			X_ONE:   mul_req.x = MOD_BITS'(1);
			X_R:     mul_req.x = r_q;
			default: mul_req.x = r_q;
		endcase
		case (uc.ysel)
			Y_GEN:   mul_req.y = gen_w;
			Y_R:     mul_req.y = r_q;
			Y_BASE:  mul_req.y = base;
			default: mul_req.y = r_q;
		endcase
	end

	assign in_stall = (uc.op != U_ACCEPT);

	dhsk_modmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.m      (p_w),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// config, sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q     <= PRIME_RST;
			gen_q       <= GEN_RST;
			step_q      <= S_ACCEPT;
			mwait_q     <= 1'b0;
			ebit_q      <= '0;
			pass_q      <= PASS_PUB_A;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PRIME: prime_q <= cfg_data;
					REG_GEN:   gen_q   <= cfg_data;
					default:   ;
				endcase
			end
			step_q <= step_nxt;
			if (mul_req.start) begin
				mwait_q <= 1'b1;
			end else if (mul_rsp.done) begin
				mwait_q <= 1'b0;
			end
			case (uc.op)
				U_SETG:  pass_q <= PASS_PUB_A;
				U_INIT:  ebit_q <= EBIT_W'(EXP_BITS - 1);
				U_LOOP:  if (ebit_q != '0) ebit_q <= ebit_q - 1'b1;
				U_SAVE:  pass_q <= pass_t'(2'(pass_q + 1'b1));
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			a_q <= in_data.first_secret;
			b_q <= in_data.second_secret;
		end
		case (uc.op)
			U_MUL:  if (mul_rsp.done) r_q <= mul_rsp.prod;
			U_SETG: gr_q <= r_q;
			U_INIT: r_q <= MOD_BITS'(1);
			U_SAVE: begin
				case (pass_q)
					PASS_PUB_A: pa_q <= r_q;
					PASS_PUB_B: pb_q <= r_q;
					PASS_KEY_A: ka_q <= r_q;
					PASS_KEY_B: kb_q <= r_q;
					default:    ;
				endcase
			end
			default: ;
		endcase
		if (out_load) begin
			if (uc.op == U_EMITZ) begin
				out_q <= '{first_public: '0, second_public: '0, shared_key: '0,
					keys_agree: 1'b1};
			end else begin
				out_q <= '{first_public: 32'(pa_q), second_public: 32'(pb_q),
					shared_key: 32'(ka_q), keys_agree: (ka_q == kb_q)};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/core/dhsk_modmul.sv]
// Iterative modular multiplier: one double-and-add step per cycle, top bit of y first.
module dhsk_modmul import dhsk_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [MOD_BITS-1:0] m,
	input  mul_req_t            req,
	output mul_rsp_t            rsp
);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] x_q;
	logic [MOD_BITS-1:0] y_q;

	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS-1:0] dbl_red;
	logic [MOD_BITS-1:0] acc_nxt;
	logic                load;

	assign load = req.start && !busy_q;

	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? MOD_BITS'(dbl - {1'b0, m}) : MOD_BITS'(dbl);
		sum     = {1'b0, dbl_red} + {1'b0, x_q};
		if (y_q[MOD_BITS-1]) begin
			acc_nxt = (sum >= {1'b0, m}) ? MOD_BITS'(sum - {1'b0, m}) : MOD_BITS'(sum);
		end else begin
			acc_nxt = dbl_red;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= '0;
			x_q   <= req.x;
			y_q   <= req.y;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			y_q   <= {y_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, prod: acc_q};

endmodule

[rtl/core/dhsk_checker.sv]
// Port-level checker for the shared-key block, bound to the top level.
`include "diffie_hellman_shared_key_assert.svh"

module dhsk_checker import dhsk_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// one item at a time: a transfer in closes the input for the next cycle
	`DHSK_ASSERT_NEXT(a_in_busy_after_take, in_valid && !in_stall, in_stall)

	// both sides compute g^(ab) mod p, so the keys match; a modulus below two sets keys_agree directly
	`DHSK_ASSERT_NOW(a_keys_agree, out_valid, out_data.keys_agree)

	`DHSK_ASSERT_NEXT(a_out_valid_held, out_valid && out_stall, out_valid)

	`DHSK_ASSERT_NEXT(a_out_data_held, out_valid && out_stall, $stable(out_data))

endmodule

bind diffie_hellman_shared_key dhsk_checker u_dhsk_checker (.*);
